// File: rtl/irig_fs_pkg.sv
// ============================================================================
// irig_fs_pkg - shared types and constants for the pulse frame synchronizer
// Beat formats, symbol codes, register map and the window bound set.
// ============================================================================
`default_nettype none

package irig_fs_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BOUND_W = 16;
    localparam int unsigned SYM_W   = 2;
    localparam int unsigned POS_W   = 7;

    // Symbol codes
    localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_MARK = 2'd2;
    localparam logic [SYM_W-1:0] SYM_NONE = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MARK_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MARK_MAX = 3'd5;
    localparam int unsigned ADDR_W = 5;

    // Reset values of the window bounds
    localparam logic [BOUND_W-1:0] ZERO_MIN_RST = 16'd1500;
    localparam logic [BOUND_W-1:0] ZERO_MAX_RST = 16'd2500;
    localparam logic [BOUND_W-1:0] ONE_MIN_RST  = 16'd4500;
    localparam logic [BOUND_W-1:0] ONE_MAX_RST  = 16'd5500;
    localparam logic [BOUND_W-1:0] MARK_MIN_RST = 16'd7500;
    localparam logic [BOUND_W-1:0] MARK_MAX_RST = 16'd8500;

    typedef logic [SYM_W-1:0] sym_t;

    // Input beat: one line change event
    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] time_us;
    } ev_beat_t;

    // Output beat: one frame symbol
    typedef struct packed {
        sym_t             symbol;
        logic [POS_W-1:0] position;
        logic             frame_last;
    } sym_beat_t;

    // Configured window bounds
    typedef struct packed {
        logic [BOUND_W-1:0] zero_min_us;
        logic [BOUND_W-1:0] zero_max_us;
        logic [BOUND_W-1:0] one_min_us;
        logic [BOUND_W-1:0] one_max_us;
        logic [BOUND_W-1:0] mark_min_us;
        logic [BOUND_W-1:0] mark_max_us;
    } bounds_t;

    // Queue write side
    typedef struct packed {
        logic push;
        sym_t sym;
    } q_wr_t;

    // Queue read side and status
    typedef struct packed {
        logic empty;
        logic full;
        sym_t sym;
    } q_rd_t;

endpackage

`default_nettype wire

// File: rtl/irig_fs_front.sv
// ============================================================================
// irig_fs_front - pulse measurement and classification
// Tracks the line level, measures each high pulse with wrapping subtraction
// and classifies it against the three windows; valid symbols enter the queue.
// ============================================================================
`default_nettype none

module irig_fs_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  irig_fs_pkg::ev_beat_t ev,
    input  irig_fs_pkg::bounds_t bounds,
    output irig_fs_pkg::q_wr_t   q_wr
);

    logic                            pulse_high_reg;
    logic                            pulse_high_next;
    logic [irig_fs_pkg::TIME_W-1:0]  rise_time_reg;
    logic [irig_fs_pkg::TIME_W-1:0]  rise_time_next;
    logic [irig_fs_pkg::TIME_W-1:0]  width;
    logic [irig_fs_pkg::BOUND_W-1:0] w16;
    logic                            short_pulse;
    logic                            in_zero;
    logic                            in_one;
    logic                            in_mark;
    irig_fs_pkg::sym_t               sym;

    // Pulse width; anything at or above 2^16 fits no 16-bit window
    assign width       = ev.time_us - rise_time_reg;
    assign w16         = width[irig_fs_pkg::BOUND_W-1:0];
    assign short_pulse = (width[irig_fs_pkg::TIME_W-1:irig_fs_pkg::BOUND_W] == '0);

    // Strict window compares
    assign in_zero = short_pulse && (w16 > bounds.zero_min_us) && (w16 < bounds.zero_max_us);
    assign in_one  = short_pulse && (w16 > bounds.one_min_us)  && (w16 < bounds.one_max_us);
    assign in_mark = short_pulse && (w16 > bounds.mark_min_us) && (w16 < bounds.mark_max_us);

    // First matching window wins
    always_comb
    begin
        if (in_zero)
            sym = irig_fs_pkg::SYM_ZERO;
        else if (in_one)
            sym = irig_fs_pkg::SYM_ONE;
        else if (in_mark)
            sym = irig_fs_pkg::SYM_MARK;
        else
            sym = irig_fs_pkg::SYM_NONE;
    end

    // Level tracking; repeated levels are ignored
    always_comb
    begin
        pulse_high_next = pulse_high_reg;
        rise_time_next  = rise_time_reg;
        q_wr.push       = 1'b0;
        q_wr.sym        = sym;
        if (accept)
        begin
            if (!pulse_high_reg)
            begin
                if (ev.level)
                begin
                    pulse_high_next = 1'b1;
                    rise_time_next  = ev.time_us;
                end
            end
            else if (!ev.level)
            begin
                pulse_high_next = 1'b0;
                q_wr.push       = (sym != irig_fs_pkg::SYM_NONE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_high_reg <= 1'b0;
            rise_time_reg  <= '0;
        end
        else
        begin
            pulse_high_reg <= pulse_high_next;
            rise_time_reg  <= rise_time_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/irig_fs_fifo.sv
// ============================================================================
// irig_fs_fifo - symbol queue between classifier and synchronizer
// Small register FIFO; one push and one pop per cycle, a push only while not full and a pop only while not empty.
// ============================================================================
`default_nettype none

module irig_fs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                clk,
    input  wire                rst_n,
    input  irig_fs_pkg::q_wr_t q_wr,
    input  wire                pop,
    output irig_fs_pkg::q_rd_t q_rd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    irig_fs_pkg::sym_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = q_wr.push && (count_reg != FULL_CNT);
    assign do_pop  = pop && (count_reg != '0);

    assign q_rd.empty = (count_reg == '0);
    assign q_rd.full  = (count_reg == FULL_CNT);
    assign q_rd.sym   = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_wr.sym;
    end

endmodule

`default_nettype wire

// File: rtl/irig_fs_back.sv
// ============================================================================
// irig_fs_back - frame synchronizer
// Hunts for a marker pair, then numbers the frame's symbols into an output
// register; the marker pair takes two output beats.
// ============================================================================
`default_nettype none

module irig_fs_back #(
    parameter int FRAME_SYMBOLS = 100
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  irig_fs_pkg::q_rd_t     q_rd,
    output logic                   pop,
    output logic                   sym_valid,
    input  wire                    sym_stall,
    output irig_fs_pkg::sym_beat_t sym
);

    localparam int PW = irig_fs_pkg::POS_W;
    localparam logic [PW:0] FRAME_END = (PW + 1)'(FRAME_SYMBOLS);

    typedef enum logic [2:0] {
        SYNC_HUNT  = 3'b001,
        SYNC_ONE   = 3'b010,
        SYNC_FRAME = 3'b100
    } sync_t;

    sync_t                  state_reg;
    sync_t                  state_next;
    logic [PW-1:0]          count_reg;
    logic [PW-1:0]          count_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   valid_reg;
    logic                   valid_next;
    irig_fs_pkg::sym_beat_t beat_reg;
    irig_fs_pkg::sym_beat_t beat_next;
    logic                   load_ok;
    logic [PW:0]            count_inc;
    logic                   last;

    assign load_ok   = !valid_reg || !sym_stall;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign last      = (count_inc >= FRAME_END);

    assign sym_valid = valid_reg;
    assign sym       = beat_reg;

    // Sync sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        pop        = 1'b0;
        if (load_ok)
        begin
            valid_next = 1'b0;
            if (pend_reg)
            begin
                // second beat of the marker pair
                valid_next           = 1'b1;
                beat_next.symbol     = irig_fs_pkg::SYM_MARK;
                beat_next.position   = PW'(1);
                beat_next.frame_last = 1'b0;
                pend_next            = 1'b0;
            end
            else if (!q_rd.empty)
            begin
                pop = 1'b1;
                unique case (state_reg)
                    SYNC_ONE:
                    begin
                        if (q_rd.sym == irig_fs_pkg::SYM_MARK)
                        begin
                            valid_next           = 1'b1;
                            beat_next.symbol     = irig_fs_pkg::SYM_MARK;
                            beat_next.position   = '0;
                            beat_next.frame_last = 1'b0;
                            pend_next            = 1'b1;
                            state_next           = SYNC_FRAME;
                            count_next           = PW'(2);
                        end
                        else
                        begin
                            state_next = SYNC_HUNT;
                            count_next = '0;
                        end
                    end
                    SYNC_FRAME:
                    begin
                        valid_next           = 1'b1;
                        beat_next.symbol     = q_rd.sym;
                        beat_next.position   = count_reg;
                        beat_next.frame_last = last;
                        if (last)
                        begin
                            state_next = SYNC_HUNT;
                            count_next = '0;
                        end
                        else
                            count_next = count_inc[PW-1:0];
                    end
                    default:
                    begin
                        if (q_rd.sym == irig_fs_pkg::SYM_MARK)
                        begin
                            state_next = SYNC_ONE;
                            count_next = PW'(1);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SYNC_HUNT;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

endmodule

`default_nettype wire

// File: rtl/irig_b_pulse_frame_sync.sv
// ============================================================================
// irig_b_pulse_frame_sync - pulse classifier and frame synchronizer
// Measures high pulses of a time code line, classifies them as zero, one or
// marker, locks on a marker pair and streams the frame's numbered symbols.
// ============================================================================
// One line change event is accepted every clock cycle while the symbol queue
// has room; the classifier does the width subtract and window compares in
// the accept cycle. A queued symbol moves into the output register once that
// register is empty or its beat is taken. The synchronizer delivers at most
// one beat per cycle, and none while the receiver stalls; the marker pair
// that starts a frame takes two output beats. Window bounds are programmed
// over the register port at byte addresses 0x00 to 0x14 and are meant to be
// changed only while no beat is in flight.
`default_nettype none

module irig_b_pulse_frame_sync #(
    parameter int FRAME_SYMBOLS = 100,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // event channel
    input  wire                                ev_valid,
    output logic                               ev_stall,
    input  irig_fs_pkg::ev_beat_t              ev,
    // symbol channel
    output logic                               sym_valid,
    input  wire                                sym_stall,
    output irig_fs_pkg::sym_beat_t             sym,
    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [irig_fs_pkg::ADDR_W-1:0]      paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    irig_fs_pkg::bounds_t                bounds_reg;
    irig_fs_pkg::bounds_t                bounds_next;
    irig_fs_pkg::q_wr_t                  q_wr;
    irig_fs_pkg::q_rd_t                  q_rd;
    logic                                q_pop;
    logic                                ev_accept;
    logic                                cfg_wr;
    logic [irig_fs_pkg::REG_IDX_W-1:0]   reg_idx;
    logic [irig_fs_pkg::BOUND_W-1:0]     rd_val;
    logic [irig_fs_pkg::BOUND_W-1:0]     wr_val;

    assign pready    = 1'b1;
    assign ev_stall  = q_rd.full;
    assign ev_accept = ev_valid && !ev_stall;

    // Register decode
    assign reg_idx = paddr[irig_fs_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[irig_fs_pkg::BOUND_W-1:0];

    always_comb
    begin
        bounds_next = bounds_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                irig_fs_pkg::REG_ZERO_MIN: bounds_next.zero_min_us = wr_val;
                irig_fs_pkg::REG_ZERO_MAX: bounds_next.zero_max_us = wr_val;
                irig_fs_pkg::REG_ONE_MIN:  bounds_next.one_min_us  = wr_val;
                irig_fs_pkg::REG_ONE_MAX:  bounds_next.one_max_us  = wr_val;
                irig_fs_pkg::REG_MARK_MIN: bounds_next.mark_min_us = wr_val;
                irig_fs_pkg::REG_MARK_MAX: bounds_next.mark_max_us = wr_val;
                default:                   bounds_next = bounds_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            irig_fs_pkg::REG_ZERO_MIN: rd_val = bounds_reg.zero_min_us;
            irig_fs_pkg::REG_ZERO_MAX: rd_val = bounds_reg.zero_max_us;
            irig_fs_pkg::REG_ONE_MIN:  rd_val = bounds_reg.one_min_us;
            irig_fs_pkg::REG_ONE_MAX:  rd_val = bounds_reg.one_max_us;
            irig_fs_pkg::REG_MARK_MIN: rd_val = bounds_reg.mark_min_us;
            irig_fs_pkg::REG_MARK_MAX: rd_val = bounds_reg.mark_max_us;
            default:                   rd_val = '0;
        endcase
    end

    assign prdata = {{(32 - irig_fs_pkg::BOUND_W){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.zero_min_us <= irig_fs_pkg::ZERO_MIN_RST;
            bounds_reg.zero_max_us <= irig_fs_pkg::ZERO_MAX_RST;
            bounds_reg.one_min_us  <= irig_fs_pkg::ONE_MIN_RST;
            bounds_reg.one_max_us  <= irig_fs_pkg::ONE_MAX_RST;
            bounds_reg.mark_min_us <= irig_fs_pkg::MARK_MIN_RST;
            bounds_reg.mark_max_us <= irig_fs_pkg::MARK_MAX_RST;
        end
        else
            bounds_reg <= bounds_next;
    end

    // Front: measure and classify
    irig_fs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (ev_accept),
        .ev     (ev),
        .bounds (bounds_reg),
        .q_wr   (q_wr)
    );

    // Symbol queue
    irig_fs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .q_rd  (q_rd)
    );

    // Back: frame sync
    irig_fs_back #(
        .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .pop       (q_pop),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym)
    );

    // Checks
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_rd.full && q_rd.empty))
        else $error("queue reports full and empty at once");

    a_no_none_out: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid |-> (sym.symbol != irig_fs_pkg::SYM_NONE))
        else $error("unclassified symbol on output");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && sym.frame_last) |->
            (sym.position == irig_fs_pkg::POS_W'(FRAME_SYMBOLS - 1)))
        else $error("frame_last at wrong position");

    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && !sym_stall && (sym.position == '0)) |=>
            (sym_valid && (sym.position == irig_fs_pkg::POS_W'(1))
             && (sym.symbol == irig_fs_pkg::SYM_MARK)))
        else $error("marker pair second beat missing");

endmodule

`default_nettype wire

// File: verif/irig_b_pulse_frame_sync_checker.sv
// ============================================================================
// irig_b_pulse_frame_sync_checker - symbol stream scoreboard
// Watches the event, symbol and register channels of the frame synchronizer.
// Keeps its own copy of the window bounds and the pulse and lock state,
// predicts the symbol beats of every accepted event and compares each beat
// taken from the block field by field against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module irig_b_pulse_frame_sync_checker #(
    parameter int FRAME_SYMBOLS = 100
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              ev_valid,
    input  wire                              ev_stall,
    input  irig_fs_pkg::ev_beat_t            ev,
    input  wire                              sym_valid,
    input  wire                              sym_stall,
    input  irig_fs_pkg::sym_beat_t           sym,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [irig_fs_pkg::ADDR_W-1:0]    paddr,
    input  wire [31:0]                       pwdata,
    input  wire [31:0]                       prdata,
    input  wire                              pready,
    input  wire                              done,
    output int unsigned                      pending,
    output int                               errors
);

    typedef enum logic [1:0] {LOCK_HUNT, LOCK_ONE_MARK, LOCK_FRAME} lock_t;

    // Model copy of the window bounds and synchronizer state
    logic [irig_fs_pkg::BOUND_W-1:0]   bound_regs [irig_fs_pkg::REG_MARK_MAX+1];
    logic                              in_pulse;
    logic [irig_fs_pkg::TIME_W-1:0]    pulse_start;
    lock_t                             lock;
    logic [irig_fs_pkg::POS_W-1:0]     slot;
    irig_fs_pkg::sym_beat_t            expected_symbols [$];
    irig_fs_pkg::sym_beat_t            want;
    logic [irig_fs_pkg::REG_IDX_W-1:0] reg_idx;
    bit                                done_seen;

    initial
    begin
        errors    = 0;
        done_seen = 1'b0;
    end

    task automatic report(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    // Strict window compare; a 32-bit width never fits a window once >= 65535
    function automatic logic hit(input logic [irig_fs_pkg::TIME_W-1:0] w,
                                 input logic [irig_fs_pkg::BOUND_W-1:0] lo,
                                 input logic [irig_fs_pkg::BOUND_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    // First matching window wins: zero, then one, then marker
    function automatic irig_fs_pkg::sym_t width_to_symbol(
        input logic [irig_fs_pkg::TIME_W-1:0] w);
        if (hit(w, bound_regs[irig_fs_pkg::REG_ZERO_MIN], bound_regs[irig_fs_pkg::REG_ZERO_MAX]))
            return irig_fs_pkg::SYM_ZERO;
        if (hit(w, bound_regs[irig_fs_pkg::REG_ONE_MIN], bound_regs[irig_fs_pkg::REG_ONE_MAX]))
            return irig_fs_pkg::SYM_ONE;
        if (hit(w, bound_regs[irig_fs_pkg::REG_MARK_MIN], bound_regs[irig_fs_pkg::REG_MARK_MAX]))
            return irig_fs_pkg::SYM_MARK;
        return irig_fs_pkg::SYM_NONE;
    endfunction

    // Pulse measurement and frame lock for one accepted event beat
    task automatic track_line_event(input irig_fs_pkg::ev_beat_t e);
        irig_fs_pkg::sym_t s;
        logic last;
        if (!in_pulse)
        begin
            if (e.level)
            begin
                in_pulse    = 1'b1;
                pulse_start = e.time_us;
            end
            return;
        end
        // repeated high level: keep the original start time
        if (e.level)
            return;
        in_pulse = 1'b0;
        s = width_to_symbol(e.time_us - pulse_start);
        if (s == irig_fs_pkg::SYM_NONE)
            return;
        case (lock)
            LOCK_ONE_MARK:
            begin
                if (s == irig_fs_pkg::SYM_MARK)
                begin
                    expected_symbols.push_back(irig_fs_pkg::sym_beat_t'{
                        irig_fs_pkg::SYM_MARK, irig_fs_pkg::POS_W'(0), 1'b0});
                    expected_symbols.push_back(irig_fs_pkg::sym_beat_t'{
                        irig_fs_pkg::SYM_MARK, irig_fs_pkg::POS_W'(1), 1'b0});
                    lock = LOCK_FRAME;
                    slot = irig_fs_pkg::POS_W'(2);
                end
                else
                begin
                    // broken pair: back to hunting, this symbol is not a new start
                    lock = LOCK_HUNT;
                    slot = '0;
                end
            end
            LOCK_FRAME:
            begin
                last = (int'(slot) + 1 >= FRAME_SYMBOLS);
                expected_symbols.push_back(irig_fs_pkg::sym_beat_t'{s, slot, last});
                if (last)
                begin
                    lock = LOCK_HUNT;
                    slot = '0;
                end
                else
                    slot = slot + 1'b1;
            end
            default:
            begin
                if (s == irig_fs_pkg::SYM_MARK)
                begin
                    lock = LOCK_ONE_MARK;
                    slot = irig_fs_pkg::POS_W'(1);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_regs[irig_fs_pkg::REG_ZERO_MIN] = irig_fs_pkg::ZERO_MIN_RST;
            bound_regs[irig_fs_pkg::REG_ZERO_MAX] = irig_fs_pkg::ZERO_MAX_RST;
            bound_regs[irig_fs_pkg::REG_ONE_MIN]  = irig_fs_pkg::ONE_MIN_RST;
            bound_regs[irig_fs_pkg::REG_ONE_MAX]  = irig_fs_pkg::ONE_MAX_RST;
            bound_regs[irig_fs_pkg::REG_MARK_MIN] = irig_fs_pkg::MARK_MIN_RST;
            bound_regs[irig_fs_pkg::REG_MARK_MAX] = irig_fs_pkg::MARK_MAX_RST;
            in_pulse    = 1'b0;
            pulse_start = '0;
            lock        = LOCK_HUNT;
            slot        = '0;
            expected_symbols.delete();
            pending <= 0;
        end
        else
        begin
            // register port: writes outside the map are dropped
            if (psel && penable && pready)
            begin
                reg_idx = paddr[irig_fs_pkg::ADDR_W-1:2];
                if (reg_idx <= irig_fs_pkg::REG_MARK_MAX)
                begin
                    if (pwrite)
                        bound_regs[reg_idx] = pwdata[irig_fs_pkg::BOUND_W-1:0];
                    else if (prdata !== {16'h0, bound_regs[reg_idx]})
                        report($sformatf("register %0d read 0x%08h, expected 0x%04h",
                                         reg_idx, prdata, bound_regs[reg_idx]));
                end
            end

            // symbol beat against the oldest prediction
            if (sym_valid && !sym_stall)
            begin
                if (expected_symbols.size() == 0)
                    report($sformatf("unexpected beat: symbol %0d position %0d last %0b",
                                     sym.symbol, sym.position, sym.frame_last));
                else
                begin
                    want = expected_symbols.pop_front();
                    if (sym.symbol !== want.symbol)
                        report($sformatf("position %0d: symbol %0d, expected %0d",
                                         want.position, sym.symbol, want.symbol));
                    if (sym.position !== want.position)
                        report($sformatf("position %0d, expected %0d",
                                         sym.position, want.position));
                    if (sym.frame_last !== want.frame_last)
                        report($sformatf("position %0d: frame_last %0b, expected %0b",
                                         want.position, sym.frame_last, want.frame_last));
                end
            end

            if (ev_valid && !ev_stall)
                track_line_event(ev);

            if (done && !done_seen)
            begin
                done_seen = 1'b1;
                if (expected_symbols.size() != 0)
                    report($sformatf("%0d expected beats never arrived",
                                     expected_symbols.size()));
            end

            pending <= expected_symbols.size();
        end
    end

endmodule

// File: verif/irig_b_pulse_frame_sync_test.sv
// ============================================================================
// irig_b_pulse_frame_sync_test - testbench top for the frame synchronizer
// Drives line change events as pulse trains: a short directed run over the
// window edges, repeated levels, broken marker pairs and timestamp wrap, then
// random frames with stray pulses under four window settings and three
// idle/stall mixes. A separate checker predicts and scores the symbol beats.
// ============================================================================
`timescale 1ns / 1ps

module irig_b_pulse_frame_sync_test;

    localparam int FRAME_SYMBOLS = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_EVENTS  = 180;
    localparam int MAX_GAP_US    = 20000;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int TW            = irig_fs_pkg::TIME_W;
    localparam int BW            = irig_fs_pkg::BOUND_W;
    localparam int IW            = irig_fs_pkg::REG_IDX_W;

    // addresses past the bound registers, expected to ignore writes
    localparam logic [IW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_B = 3'd7;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            ev_valid  = 1'b0;
    irig_fs_pkg::ev_beat_t           ev        = '0;
    logic                            sym_stall = 1'b0;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [irig_fs_pkg::ADDR_W-1:0]  paddr     = '0;
    logic [31:0]                     pwdata    = '0;
    logic                            done      = 1'b0;

    logic                            ev_stall;
    logic                            sym_valid;
    irig_fs_pkg::sym_beat_t          sym;
    logic [31:0]                     prdata;
    logic                            pready;
    int unsigned                     pending;
    int                              errors;

    // stimulus state
    int                 snd_idle_pct  = 0;
    int                 rcv_stall_pct = 0;
    int unsigned        ev_count      = 0;
    logic [TW-1:0]      t_now         = '0;
    logic [BW-1:0]      win_lo [3];
    logic [BW-1:0]      win_hi [3];

    irig_b_pulse_frame_sync #(
        .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_stall  (ev_stall),
        .ev        (ev),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    irig_b_pulse_frame_sync_checker #(
        .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_stall  (ev_stall),
        .ev        (ev),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .done      (done),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // random receiver stalls
    always @(posedge clk)
    begin
        sym_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One event beat; returns at the edge that accepts it
    task automatic send_ev(input logic lvl, input logic [TW-1:0] t);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            ev_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        ev_valid <= 1'b1;
        ev       <= irig_fs_pkg::ev_beat_t'{level: lvl, time_us: t};
        @(posedge clk);
        while (ev_stall)
            @(posedge clk);
        ev_count++;
    endtask

    task automatic send_pulse(input logic [TW-1:0] gap, input logic [TW-1:0] width);
        t_now += gap;
        send_ev(1'b1, t_now);
        t_now += width;
        send_ev(1'b0, t_now);
    endtask

    // Width inside the window of a symbol, edges favored; empty windows probed
    function automatic logic [TW-1:0] width_for(input irig_fs_pkg::sym_t k);
        int lo;
        int hi;
        lo = win_lo[k];
        hi = win_hi[k];
        if (hi - lo < 2)
            return lo + $urandom_range(2);
        case ($urandom_range(7))
            0:       return lo + 1;
            1:       return hi - 1;
            default: return $urandom_range(hi - 1, lo + 1);
        endcase
    endfunction

    // Stray width: exact bounds, long or arbitrary pulses, not always outside every window
    function automatic logic [TW-1:0] stray_width();
        irig_fs_pkg::sym_t k;
        k = irig_fs_pkg::sym_t'($urandom_range(2));
        case ($urandom_range(4))
            0:       return win_lo[k];
            1:       return win_hi[k];
            2:       return 32'd65535 + $urandom_range(2);
            3:       return $urandom;
            default: return $urandom_range(65535);
        endcase
    endfunction

    // Noise: low level while idle, repeated high level, or a stray width
    task automatic send_stray();
        case ($urandom_range(3))
            0:
            begin
                t_now += $urandom_range(MAX_GAP_US);
                send_ev(1'b0, t_now);
            end
            1:
            begin
                t_now += $urandom_range(MAX_GAP_US);
                send_ev(1'b1, t_now);
                send_ev(1'b1, t_now + $urandom_range(3000));
                t_now += width_for(irig_fs_pkg::sym_t'($urandom_range(2)));
                send_ev(1'b0, t_now);
            end
            default: send_pulse($urandom_range(MAX_GAP_US), stray_width());
        endcase
    endtask

    // Marker pair, then the rest of the frame with random symbols and noise
    task automatic send_frame();
        send_pulse($urandom_range(MAX_GAP_US), width_for(irig_fs_pkg::SYM_MARK));
        send_pulse($urandom_range(MAX_GAP_US), width_for(irig_fs_pkg::SYM_MARK));
        repeat (FRAME_SYMBOLS - 2)
        begin
            if ($urandom_range(19) == 0)
                send_stray();
            send_pulse($urandom_range(MAX_GAP_US),
                       width_for(irig_fs_pkg::sym_t'($urandom_range(2))));
        end
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned stop;
        stop  = ev_count + budget;
        t_now = $urandom;
        while (ev_count < stop)
        begin
            case ($urandom_range(9))
                6, 7:
                begin
                    // marker followed by a data symbol
                    send_pulse($urandom_range(MAX_GAP_US), width_for(irig_fs_pkg::SYM_MARK));
                    send_pulse($urandom_range(MAX_GAP_US),
                               width_for(irig_fs_pkg::sym_t'($urandom_range(1))));
                end
                8:       send_pulse($urandom_range(MAX_GAP_US),
                                    width_for(irig_fs_pkg::sym_t'($urandom_range(2))));
                9:       send_stray();
                default: send_frame();
            endcase
        end
    endtask

    // Wait until every predicted beat is out and the pipe is quiet
    task automatic settle();
        ev_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle
    task automatic reg_access(input logic wr, input logic [IW-1:0] idx,
                              input logic [BW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic read_all_regs();
        for (int i = 0; i <= REG_SPARE_B; i++)
            reg_access(1'b0, IW'(i), '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_windows(input logic [BW-1:0] zlo, input logic [BW-1:0] zhi,
                                   input logic [BW-1:0] olo, input logic [BW-1:0] ohi,
                                   input logic [BW-1:0] mlo, input logic [BW-1:0] mhi);
        settle();
        reg_access(1'b1, irig_fs_pkg::REG_ZERO_MIN, zlo);
        reg_access(1'b1, irig_fs_pkg::REG_ZERO_MAX, zhi);
        reg_access(1'b1, irig_fs_pkg::REG_ONE_MIN, olo);
        reg_access(1'b1, irig_fs_pkg::REG_ONE_MAX, ohi);
        reg_access(1'b1, irig_fs_pkg::REG_MARK_MIN, mlo);
        reg_access(1'b1, irig_fs_pkg::REG_MARK_MAX, mhi);
        reg_access(1'b1, REG_SPARE_A, 16'($urandom));
        reg_access(1'b1, REG_SPARE_B, 16'($urandom));
        read_all_regs();
        win_lo[irig_fs_pkg::SYM_ZERO] = zlo;
        win_hi[irig_fs_pkg::SYM_ZERO] = zhi;
        win_lo[irig_fs_pkg::SYM_ONE]  = olo;
        win_hi[irig_fs_pkg::SYM_ONE]  = ohi;
        win_lo[irig_fs_pkg::SYM_MARK] = mlo;
        win_hi[irig_fs_pkg::SYM_MARK] = mhi;
    endtask

    // Directed run with the reset windows
    task automatic directed_run();
        t_now = $urandom;
        // low level with no pulse open
        send_ev(1'b0, t_now);
        // repeated high level: width counts from the first rise
        t_now += 100;
        send_ev(1'b1, t_now);
        send_ev(1'b1, t_now + 1000);
        t_now += win_hi[irig_fs_pkg::SYM_ZERO] - 1;
        send_ev(1'b0, t_now);
        // exclusive bounds of the zero window
        send_pulse(3000, win_lo[irig_fs_pkg::SYM_ZERO]);
        send_pulse(3000, win_lo[irig_fs_pkg::SYM_ZERO] + 1);
        send_pulse(3000, win_hi[irig_fs_pkg::SYM_ZERO]);
        // first marker, broken by a one, then a fresh pair across time wrap
        send_pulse(3000, win_hi[irig_fs_pkg::SYM_MARK] - 1);
        send_pulse(3000, win_lo[irig_fs_pkg::SYM_ONE] + 1);
        send_pulse(3000, win_lo[irig_fs_pkg::SYM_MARK] + 1);
        t_now = 32'hFFFF_E000;
        send_pulse(32'h1000, win_lo[irig_fs_pkg::SYM_MARK] + 500);
        // long pulse whose low half looks like a marker
        send_pulse(3000, 32'h0001_0000 + win_lo[irig_fs_pkg::SYM_MARK] + 1);
        // marker inside a frame is an ordinary symbol
        send_pulse(3000, win_lo[irig_fs_pkg::SYM_MARK] + 1);
        send_pulse(3000, win_hi[irig_fs_pkg::SYM_ONE] - 1);
    endtask

    initial
    begin
        logic [BW-1:0] olo;
        logic [BW-1:0] ohi;
        logic [BW-1:0] mlo;

        win_lo[irig_fs_pkg::SYM_ZERO] = irig_fs_pkg::ZERO_MIN_RST;
        win_hi[irig_fs_pkg::SYM_ZERO] = irig_fs_pkg::ZERO_MAX_RST;
        win_lo[irig_fs_pkg::SYM_ONE]  = irig_fs_pkg::ONE_MIN_RST;
        win_hi[irig_fs_pkg::SYM_ONE]  = irig_fs_pkg::ONE_MAX_RST;
        win_lo[irig_fs_pkg::SYM_MARK] = irig_fs_pkg::MARK_MIN_RST;
        win_hi[irig_fs_pkg::SYM_MARK] = irig_fs_pkg::MARK_MAX_RST;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_all_regs();

        // reset windows, slow receiver
        snd_idle_pct  = 23;
        rcv_stall_pct = 59;
        directed_run();
        random_phase(PHASE_EVENTS);

        // overlapping windows, slow sender
        program_windows(16'd100, 16'd3000, 16'd2000, 16'd5000, 16'd4000, 16'd9000);
        snd_idle_pct  = 59;
        rcv_stall_pct = 23;
        random_phase(PHASE_EVENTS);

        // extreme bounds: zero window empty, one and marker one width each
        program_windows(16'hFFFF, 16'h0000, 16'h0000, 16'h0002, 16'hFFFD, 16'hFFFF);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        random_phase(PHASE_EVENTS);

        // zero window of min = max - 1, random one and marker windows
        olo = $urandom_range(4000, 1000);
        ohi = olo + $urandom_range(3000, 2);
        mlo = ohi + $urandom_range(2000);
        program_windows(16'd3000, 16'd3001, olo, ohi, mlo, mlo + $urandom_range(20000, 2));
        random_phase(PHASE_EVENTS);

        settle();
        done <= 1'b1;
        repeat (2)
            @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/irig_fs_pkg.sv
rtl/irig_fs_front.sv
rtl/irig_fs_fifo.sv
rtl/irig_fs_back.sv
rtl/irig_b_pulse_frame_sync.sv
verif/irig_b_pulse_frame_sync_checker.sv
verif/irig_b_pulse_frame_sync_test.sv
